>>> sv/wbps_pkg.sv
// Shared constants and types for the wildcard byte pattern scanner.
package wbps_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int OFFSET_BITS = 32;

    localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int WIN_AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ONLY     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS   = 3'd5;

    // Match settings seen by the front end
    typedef struct packed {
        logic [127:0]     pattern;
        logic [15:0]      care;
        logic [LEN_W-1:0] len;
        logic             first_only;
    } match_cfg_t;

    // One classified item waiting for the back end
    typedef struct packed {
        logic                   report;
        logic [OFFSET_BITS-1:0] start;
        logic                   last;
        logic                   found;
    } scan_entry_t;

endpackage

>>> sv/wbps_front.sv
// Front end: takes bytes, keeps the window and decides which items give a result.
module wbps_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               data_byte,
    input  logic                     range_last,
    input  wbps_pkg::match_cfg_t     cfg,
    input  logic                     fifo_full,
    output logic                     push,
    output wbps_pkg::scan_entry_t    entry
);

    logic [wbps_pkg::PATTERN_MAX-1:0][7:0]   win_reg;
    logic [wbps_pkg::PATTERN_MAX-1:0][7:0]   win_next;
    logic [wbps_pkg::LEN_W-1:0]              fill_reg;
    logic [wbps_pkg::LEN_W-1:0]              fill_next;
    logic [wbps_pkg::OFFSET_BITS-1:0]        pos_reg;
    logic                                    found_reg;
    logic                                    hit;
    logic                                    match;
    logic                                    report;
    logic                                    accept;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        win_next[0] = data_byte;
        for (int k = 1; k < wbps_pkg::PATTERN_MAX; k++)
        begin
            win_next[k] = win_reg[k-1];
        end
    end

    assign fill_next = (fill_reg == wbps_pkg::LEN_W'(wbps_pkg::PATTERN_MAX)) ?
                       fill_reg : fill_reg + wbps_pkg::LEN_W'(1);

    // Signature byte i lines up with window slot len-1-i (newest at slot 0)
    always_comb
    begin
        logic [wbps_pkg::WIN_AW-1:0] widx;
        hit  = 1'b1;
        widx = '0;
        for (int i = 0; i < wbps_pkg::PATTERN_MAX; i++)
        begin
            widx = wbps_pkg::WIN_AW'(cfg.len - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(i));
            if ((wbps_pkg::LEN_W'(i) < cfg.len) && cfg.care[i] &&
                (cfg.pattern[i*8 +: 8] != win_next[widx]))
            begin
                hit = 1'b0;
            end
        end
    end

    assign match  = hit && (fill_next >= cfg.len);
    assign report = match && !(cfg.first_only && found_reg);

    assign push         = accept && (report || range_last);
    assign entry.report = report;
    assign entry.start  = pos_reg - wbps_pkg::OFFSET_BITS'(cfg.len - wbps_pkg::LEN_W'(1));
    assign entry.last   = range_last;
    assign entry.found  = found_reg || match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            pos_reg   <= '0;
            found_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (range_last)
            begin
                fill_reg  <= '0;
                pos_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                fill_reg  <= fill_next;
                pos_reg   <= pos_reg + wbps_pkg::OFFSET_BITS'(1);
                found_reg <= found_reg || match;
            end
        end
    end

    // Slots beyond the fill count are never compared, so no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg <= win_next;
        end
    end

endmodule

>>> sv/wbps_fifo.sv
// Short queue of classified items between front and back ends.
module wbps_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  wbps_pkg::scan_entry_t  push_entry,
    output logic                   full,
    input  logic                   pop,
    output logic                   head_valid,
    output wbps_pkg::scan_entry_t  head_entry
);

    wbps_pkg::scan_entry_t               mem_reg [wbps_pkg::FIFO_DEPTH];
    logic [wbps_pkg::FIFO_AW-1:0]        wr_ptr_reg;
    logic [wbps_pkg::FIFO_AW-1:0]        rd_ptr_reg;
    logic [wbps_pkg::FIFO_AW:0]          count_reg;
    logic [wbps_pkg::FIFO_AW:0]          count_next;

    assign full       = (count_reg == (wbps_pkg::FIFO_AW+1)'(wbps_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (wbps_pkg::FIFO_AW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (wbps_pkg::FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + wbps_pkg::FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + wbps_pkg::FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> sv/wbps_back.sv
// Back end: forms the address and holds the result in the output register.
module wbps_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [63:0]            base_address,
    input  logic                   head_valid,
    input  wbps_pkg::scan_entry_t  head_entry,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [63:0]            match_address,
    output logic                   is_match,
    output logic                   scan_end,
    output logic                   any_found
);

    logic        out_valid_reg;
    logic [63:0] addr_reg;
    logic        is_match_reg;
    logic        scan_end_reg;
    logic        any_found_reg;

    assign pop = head_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            addr_reg      <= head_entry.report ?
                             base_address + 64'(head_entry.start) : 64'd0;
            is_match_reg  <= head_entry.report;
            scan_end_reg  <= head_entry.last;
            any_found_reg <= head_entry.last && head_entry.found;
        end
    end

    assign out_valid     = out_valid_reg;
    assign match_address = addr_reg;
    assign is_match      = is_match_reg;
    assign scan_end      = scan_end_reg;
    assign any_found     = any_found_reg;

endmodule

>>> sv/wildcard_byte_pattern_scan.sv
// Top level of the wildcard byte pattern scanner: config registers and datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | data_byte, range_last
//  out     | out_valid / out_ready| match_address, is_match, scan_end, any_found
//  cfg     | cfg_write            | cfg_index, cfg_data
//
// One byte per cycle while in_ready is high; a result passes through the queue and then the output register.
// The front end compares the whole window in the cycle a byte arrives; the
// back end does the 64-bit address add when it loads the output register.
// Reset restores the register defaults and clears the range state.
// A four-entry queue absorbs output stalls; in_ready drops only when it fills.
module wildcard_byte_pattern_scan (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         data_byte,
    input  logic                               range_last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [63:0]                        match_address,
    output logic                               is_match,
    output logic                               scan_end,
    output logic                               any_found,
    input  logic                               cfg_write,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [63:0]                   pattern_low_reg;
    logic [63:0]                   pattern_high_reg;
    logic [15:0]                   care_mask_reg;
    logic [4:0]                    pattern_length_reg;
    logic                          first_only_reg;
    logic [63:0]                   base_address_reg;
    logic [4:0]                    len_clamped;
    wbps_pkg::match_cfg_t          match_cfg;
    logic                          fifo_full;
    logic                          push;
    wbps_pkg::scan_entry_t         push_entry;
    logic                          pop;
    logic                          head_valid;
    wbps_pkg::scan_entry_t         head_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '0;
            pattern_length_reg <= 5'd1;
            first_only_reg     <= 1'b1;
            base_address_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                wbps_pkg::CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                wbps_pkg::CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                wbps_pkg::CFG_CARE_MASK:      care_mask_reg      <= cfg_data[15:0];
                wbps_pkg::CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[4:0];
                wbps_pkg::CFG_FIRST_ONLY:     first_only_reg     <= cfg_data[0];
                wbps_pkg::CFG_BASE_ADDRESS:   base_address_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Zero length acts as one; anything above the window size is clipped
    always_comb
    begin
        if (pattern_length_reg == 5'd0)
        begin
            len_clamped = 5'd1;
        end
        else if (pattern_length_reg > 5'(wbps_pkg::PATTERN_MAX))
        begin
            len_clamped = 5'(wbps_pkg::PATTERN_MAX);
        end
        else
        begin
            len_clamped = pattern_length_reg;
        end
    end

    assign match_cfg.pattern    = {pattern_high_reg, pattern_low_reg};
    assign match_cfg.care       = care_mask_reg;
    assign match_cfg.len        = wbps_pkg::LEN_W'(len_clamped);
    assign match_cfg.first_only = first_only_reg;

    wbps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .range_last (range_last),
        .cfg        (match_cfg),
        .fifo_full  (fifo_full),
        .push       (push),
        .entry      (push_entry)
    );

    wbps_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    wbps_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .base_address  (base_address_reg),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .match_address (match_address),
        .is_match      (is_match),
        .scan_end      (scan_end),
        .any_found     (any_found)
    );

endmodule

>>> sv/wbps_checker.sv
// Port-level checks for the scanner, bound to the top level.
module wbps_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] match_address,
    input  logic        is_match,
    input  logic        scan_end,
    input  logic        any_found
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(match_address) &&
        $stable(is_match) && $stable(scan_end) && $stable(any_found))
        else $error("result changed while stalled");

    // Only matches and range ends produce results
    a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> is_match || scan_end)
        else $error("result with neither match nor end");

    // Summary flag only on the end result, and set whenever it carries a match
    a_found_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && any_found |-> scan_end)
        else $error("any_found outside scan end");

    a_found_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_match && scan_end |-> any_found)
        else $error("match on last byte without any_found");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_match |-> match_address == 64'd0)
        else $error("address nonzero without match");

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .match_address (match_address),
    .is_match      (is_match),
    .scan_end      (scan_end),
    .any_found     (any_found)
);

>>> dv/testbench.sv
// Testbench for the wildcard byte pattern scanner: directed and random byte ranges.
`timescale 1ns / 1ps

typedef logic [7:0] byte_seq_t [$];

typedef struct packed {
    logic [63:0] address;
    logic        is_match;
    logic        scan_end;
    logic        any_found;
} scan_result_t;

// Tracks the scanner's registers and range state, predicts the result of each
// accepted byte and checks results in order.
class scan_scoreboard;
    logic [63:0] sig_low;
    logic [63:0] sig_high;
    logic [15:0] care;
    logic [4:0]  len_reg;
    logic        first_only;
    logic [63:0] base;

    logic [7:0]                       window [wbps_pkg::PATTERN_MAX];
    logic [wbps_pkg::OFFSET_BITS-1:0] position;
    logic                             found;
    int                               fill;

    scan_result_t expected_q [$];
    int           mismatches;

    function new();
        sig_low    = '0;
        sig_high   = '0;
        care       = '0;
        len_reg    = 5'd1;
        first_only = 1'b1;
        base       = '0;
        mismatches = 0;
        clear_range();
    endfunction

    function void clear_range();
        foreach (window[k])
            window[k] = 8'h00;
        position = '0;
        found    = 1'b0;
        fill     = 0;
    endfunction

    // zero counts as one, anything past the window counts as a full window
    function int active_len();
        if (len_reg == 0)
            return 1;
        if (len_reg > wbps_pkg::PATTERN_MAX)
            return wbps_pkg::PATTERN_MAX;
        return int'(len_reg);
    endfunction

    function void set_reg(logic [wbps_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
        case (idx)
            wbps_pkg::CFG_PATTERN_LOW:    sig_low    = value;
            wbps_pkg::CFG_PATTERN_HIGH:   sig_high   = value;
            wbps_pkg::CFG_CARE_MASK:      care       = value[15:0];
            wbps_pkg::CFG_PATTERN_LENGTH: len_reg    = value[4:0];
            wbps_pkg::CFG_FIRST_ONLY:     first_only = value[0];
            wbps_pkg::CFG_BASE_ADDRESS:   base       = value;
            default: ;
        endcase
    endfunction

    function void note_byte(logic [7:0] value, logic last);
        int                               len;
        logic [127:0]                     sig;
        logic [wbps_pkg::OFFSET_BITS-1:0] cur;
        logic [wbps_pkg::OFFSET_BITS-1:0] span;
        logic [wbps_pkg::OFFSET_BITS-1:0] start;
        logic                             hit;
        logic                             report;
        scan_result_t                     want;

        len = active_len();
        sig = {sig_high, sig_low};
        cur = position;
        for (int k = wbps_pkg::PATTERN_MAX - 1; k > 0; k--)
            window[k] = window[k - 1];
        window[0] = value;
        if (fill < wbps_pkg::PATTERN_MAX)
            fill++;
        position = cur + wbps_pkg::OFFSET_BITS'(1);

        // signature byte 0 lines up with the oldest of the last len bytes in the window
        hit = (fill >= len);
        for (int i = 0; i < len; i++)
            if (care[i] && sig[8*i +: 8] != window[len - 1 - i])
                hit = 1'b0;

        report = 1'b0;
        start  = '0;
        if (hit)
        begin
            span  = wbps_pkg::OFFSET_BITS'(len - 1);
            start = cur - span;
            if (!(first_only && found))
                report = 1'b1;
            found = 1'b1;
        end

        if (report || last)
        begin
            want.address   = report ? base + 64'(start) : 64'd0;
            want.is_match  = report;
            want.scan_end  = last;
            want.any_found = last && found;
            expected_q.insert(expected_q.size(), want);
        end
        if (last)
            clear_range();
    endfunction

    function void log_mismatch(string msg);
        if (mismatches < 10)
            $display("[%0t] ERROR: %s", $time, msg);
        mismatches++;
    endfunction

    function void check_result(logic [63:0] addr, logic m, logic e, logic f);
        scan_result_t want;

        if (expected_q.size() == 0)
        begin
            log_mismatch($sformatf(
                "unexpected result address=%h is_match=%b scan_end=%b any_found=%b",
                addr, m, e, f));
            return;
        end
        want = expected_q.pop_front();
        if (want.address !== addr)
            log_mismatch($sformatf("match_address expected %h got %h", want.address, addr));
        if (want.is_match !== m)
            log_mismatch($sformatf("is_match expected %b got %b", want.is_match, m));
        if (want.scan_end !== e)
            log_mismatch($sformatf("scan_end expected %b got %b", want.scan_end, e));
        if (want.any_found !== f)
            log_mismatch($sformatf("any_found expected %b got %b", want.any_found, f));
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module testbench;

    localparam int RANDOM_ITEMS = 2000;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_PAUSE  = 4;

    // indexes past the register list, written to check they are ignored
    localparam logic [wbps_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [wbps_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [7:0]                      data_byte = 8'h00;
    logic                            range_last = 1'b0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [63:0]                     match_address;
    logic                            is_match;
    logic                            scan_end;
    logic                            any_found;
    logic                            cfg_write = 1'b0;
    logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    scan_scoreboard sb;
    int             items_sent = 0;
    int             idle_cycles = 0;
    bit             sender_gaps = 1'b1;
    bit             recv_stalls = 1'b1;

    wildcard_byte_pattern_scan dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .range_last    (range_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .match_address (match_address),
        .is_match      (is_match),
        .scan_end      (scan_end),
        .any_found     (any_found),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;

        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_byte(data_byte, range_last);
            if (out_valid && out_ready)
                sb.check_result(match_address, is_match, scan_end, any_found);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[%0t] ERROR: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin : result_ready_gen
        int stall;

        while (!rst_n)
            @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            if (recv_stalls)
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    task automatic write_reg(logic [wbps_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.set_reg(idx, value);
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_byte(logic [7:0] value, logic last);
        int gap;

        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= value;
        range_last <= last;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // hold the sender until every predicted result is out, then let the pipe empty;
    // the first edge lets the monitor note a byte taken at the current edge
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic send_range(byte_seq_t seq);
        for (int i = 0; i < seq.size(); i++)
        begin
            if (i > 0 && $urandom_range(0, 49) == 0)
                drain_results();
            send_byte(seq[i], i == seq.size() - 1);
        end
    endtask

    task automatic random_setup();
        logic [63:0] v;
        int          len;

        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            default: v = {$urandom, $urandom};
        endcase
        write_reg(wbps_pkg::CFG_PATTERN_LOW, v);
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            default: v = {$urandom, $urandom};
        endcase
        write_reg(wbps_pkg::CFG_PATTERN_HIGH, v);

        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       v[15:0] = 16'h0000;
            1:       v[15:0] = 16'hFFFF;
            default: v[15:0] = 16'($urandom) | 16'($urandom);
        endcase
        write_reg(wbps_pkg::CFG_CARE_MASK, v);

        case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = 1;
            2:       len = wbps_pkg::PATTERN_MAX;
            3:       len = $urandom_range(wbps_pkg::PATTERN_MAX + 1, 31);
            default: len = $urandom_range(2, 8);
        endcase
        v = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
        v[4:0] = 5'(len);
        write_reg(wbps_pkg::CFG_PATTERN_LENGTH, v);

        v = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
        v[0] = 1'($urandom_range(0, 1));
        write_reg(wbps_pkg::CFG_FIRST_ONLY, v);

        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = '1;
            2:       v = 64'hFFFF_FFFF_FFFF_FFC0 | 64'($urandom_range(0, 63));
            default: v = {$urandom, $urandom};
        endcase
        write_reg(wbps_pkg::CFG_BASE_ADDRESS, v);

        if ($urandom_range(0, 4) == 0)
            write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI,
                      {$urandom, $urandom});
        end_writes();
    endtask

    // Random range with copies of the signature planted in it; some copies are
    // damaged in one byte, and filler leans on signature bytes for near misses.
    task automatic scan_range();
        byte_seq_t    seq;
        logic [127:0] sig;
        int           len;
        int           n;
        int           r;
        int           pos;
        int           j;

        sig = {sb.sig_high, sb.sig_low};
        len = sb.active_len();
        r = $urandom_range(0, 99);
        if (r < 70)
            n = $urandom_range(1, len + 10);
        else if (r < 95)
            n = $urandom_range(len, len + 40);
        else
            n = $urandom_range(60, 120);

        for (int i = 0; i < n; i++)
            seq.insert(seq.size(), $urandom_range(0, 1) ? sig[8*$urandom_range(0, len - 1) +: 8]
                                                        : 8'($urandom));
        if (n >= len)
        begin
            repeat ($urandom_range(0, 3))
            begin
                pos = $urandom_range(0, n - len);
                for (int i = 0; i < len; i++)
                    seq[pos + i] = sig[8*i +: 8];
                if ($urandom_range(0, 3) == 0)
                begin
                    j = $urandom_range(0, len - 1);
                    seq[pos + j] = seq[pos + j] ^ (8'h01 << $urandom_range(0, 7));
                end
            end
        end
        send_range(seq);
    endtask

    initial
    begin : stimulus
        byte_seq_t seq;
        int        random_start;

        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: one wildcard byte, first match only
        seq = '{8'h00, 8'hFF};
        send_range(seq);
        drain_results();

        // four compared bytes, report every match, address wraps past the top
        write_reg(wbps_pkg::CFG_PATTERN_LOW, 64'h0000_0000_4433_2211);
        write_reg(wbps_pkg::CFG_PATTERN_HIGH, '1);
        write_reg(wbps_pkg::CFG_CARE_MASK, 64'h0000_0000_0000_FFFF);
        write_reg(wbps_pkg::CFG_PATTERN_LENGTH, 64'd4);
        write_reg(wbps_pkg::CFG_FIRST_ONLY, 64'd0);
        write_reg(wbps_pkg::CFG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFE);
        end_writes();
        seq = '{8'h11, 8'h22, 8'h33};
        send_range(seq);
        seq = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h11, 8'h22, 8'h33, 8'h44};
        send_range(seq);
        drain_results();

        // length zero acts as one; a second hit is held back in first-only mode
        write_reg(wbps_pkg::CFG_PATTERN_LENGTH, 64'd0);
        write_reg(wbps_pkg::CFG_CARE_MASK, 64'h0000_0000_0000_0001);
        write_reg(wbps_pkg::CFG_PATTERN_LOW, 64'h5A5A_5A5A_5A5A_5AFF);
        write_reg(wbps_pkg::CFG_FIRST_ONLY, 64'd1);
        write_reg(CFG_UNMAPPED_LO, '1);
        write_reg(CFG_UNMAPPED_HI, '1);
        end_writes();
        seq = '{8'hFF, 8'h00, 8'hFF};
        send_range(seq);
        drain_results();

        // care bits past the length are ignored, so two bytes always match
        write_reg(wbps_pkg::CFG_PATTERN_LENGTH, 64'd2);
        write_reg(wbps_pkg::CFG_CARE_MASK, 64'h0000_0000_0000_FFFC);
        write_reg(wbps_pkg::CFG_FIRST_ONLY, 64'd0);
        write_reg(wbps_pkg::CFG_BASE_ADDRESS, 64'd0);
        end_writes();
        seq = '{8'hAA, 8'h55, 8'h01};
        send_range(seq);
        drain_results();

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            random_setup();
            sender_gaps = ($urandom_range(0, 3) != 0);
            recv_stalls = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 6))
                scan_range();
            drain_results();
        end

        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
            $display("[%0t] ERROR: %0d expected results never arrived", $time, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
